// ----- rtl/core/mexp_pkg.sv -----
// package for the modular exponentiation block: widths, microcode types and program rom
// no dependencies; used by every other file of the block
`default_nettype none

package mexp_pkg;

  localparam int unsigned DataW = 63;
  localparam int unsigned OpW   = 63;
  localparam int unsigned CntW  = $clog2(OpW + 1);
  localparam int unsigned PcW   = 4;

  // operation codes of the input beat
  localparam logic OpPower   = 1'b0;
  localparam logic OpInverse = 1'b1;

  typedef logic [DataW-1:0] data_t;
  typedef logic [OpW-1:0]   opnd_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [PcW-1:0]   pc_t;

  typedef enum logic [2:0] {
    CondNone,
    CondAlways,
    CondNoInput,
    CondModZero,
    CondExpZero,
    CondExpEven,
    CondMulBusy,
    CondOutFull
  } cond_e;

  typedef enum logic [1:0] {
    SelReduce,
    SelRb,
    SelBb
  } msel_e;

  typedef enum logic [1:0] {
    DstNone,
    DstB,
    DstR
  } dest_e;

  typedef struct packed {
    cond_e cond;
    pc_t   target;
    logic  in_ready;
    logic  mul_start;
    msel_e mul_sel;
    dest_e dest;
    logic  exp_shift;
    logic  emit;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic mod_zero;
    logic exp_zero;
    logic exp_odd;
    logic mul_busy;
    logic out_full;
  } status_t;

  typedef struct packed {
    logic  in_ready;
    logic  load;
    logic  mul_start;
    msel_e mul_sel;
    logic  wr_b;
    logic  wr_r;
    logic  exp_shift;
    logic  emit;
  } ctrl_t;

  // program addresses
  localparam pc_t PcIdle      = pc_t'(0);
  localparam pc_t PcChkMod    = pc_t'(1);
  localparam pc_t PcRedStart  = pc_t'(2);
  localparam pc_t PcRedWait   = pc_t'(3);
  localparam pc_t PcLoopTop   = pc_t'(4);
  localparam pc_t PcChkBit    = pc_t'(5);
  localparam pc_t PcMulStart  = pc_t'(6);
  localparam pc_t PcMulWait   = pc_t'(7);
  localparam pc_t PcSqrStart  = pc_t'(8);
  localparam pc_t PcSqrWait   = pc_t'(9);
  localparam pc_t PcShift     = pc_t'(10);
  localparam pc_t PcEmit      = pc_t'(11);
  localparam pc_t PcRestart   = pc_t'(12);

  function automatic uword_t uw(cond_e cond, pc_t target, logic in_ready, logic mul_start,
                                msel_e mul_sel, dest_e dest, logic exp_shift, logic emit);
    uword_t w;
    w.cond      = cond;
    w.target    = target;
    w.in_ready  = in_ready;
    w.mul_start = mul_start;
    w.mul_sel   = mul_sel;
    w.dest      = dest;
    w.exp_shift = exp_shift;
    w.emit      = emit;
    return w;
  endfunction

  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      PcIdle:     w = uw(CondNoInput, PcIdle,    1'b1, 1'b0, SelReduce, DstNone, 1'b0, 1'b0);
      PcChkMod:   w = uw(CondModZero, PcEmit,    1'b0, 1'b0, SelReduce, DstNone, 1'b0, 1'b0);
      PcRedStart: w = uw(CondNone,    PcIdle,    1'b0, 1'b1, SelReduce, DstNone, 1'b0, 1'b0);
      PcRedWait:  w = uw(CondMulBusy, PcRedWait, 1'b0, 1'b0, SelReduce, DstB,    1'b0, 1'b0);
      PcLoopTop:  w = uw(CondExpZero, PcEmit,    1'b0, 1'b0, SelReduce, DstNone, 1'b0, 1'b0);
      PcChkBit:   w = uw(CondExpEven, PcSqrStart, 1'b0, 1'b0, SelReduce, DstNone, 1'b0, 1'b0);
      PcMulStart: w = uw(CondNone,    PcIdle,    1'b0, 1'b1, SelRb,     DstNone, 1'b0, 1'b0);
      PcMulWait:  w = uw(CondMulBusy, PcMulWait, 1'b0, 1'b0, SelRb,     DstR,    1'b0, 1'b0);
      PcSqrStart: w = uw(CondNone,    PcIdle,    1'b0, 1'b1, SelBb,     DstNone, 1'b0, 1'b0);
      PcSqrWait:  w = uw(CondMulBusy, PcSqrWait, 1'b0, 1'b0, SelBb,     DstB,    1'b0, 1'b0);
      PcShift:    w = uw(CondAlways,  PcLoopTop, 1'b0, 1'b0, SelReduce, DstNone, 1'b1, 1'b0);
      PcEmit:     w = uw(CondOutFull, PcEmit,    1'b0, 1'b0, SelReduce, DstNone, 1'b0, 1'b1);
      PcRestart:  w = uw(CondAlways,  PcIdle,    1'b0, 1'b0, SelReduce, DstNone, 1'b0, 1'b0);
      default:    w = uw(CondAlways,  PcIdle,    1'b0, 1'b0, SelReduce, DstNone, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mexp_stream_if.sv -----
// valid/ready channel interfaces for the operand beat and the result beat
// depends on mexp_pkg for the payload types
`default_nettype none

interface mexp_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  mexp_pkg::data_t   base;
  mexp_pkg::data_t   exponent;
  mexp_pkg::data_t   modulus;

  modport source (output valid, output operation, output base, output exponent,
                  output modulus, input ready);
  modport sink   (input valid, input operation, input base, input exponent,
                  input modulus, output ready);
endinterface

interface mexp_out_if;
  logic              valid;
  logic              ready;
  mexp_pkg::data_t   result;
  logic              error;

  modport source (output valid, output result, output error, input ready);
  modport sink   (input valid, input result, input error, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mexp_mulmod.sv -----
// bit-serial shift-add-reduce modular multiplier, one multiplier bit per cycle, msb first
// depends on mexp_pkg
`default_nettype none

module mexp_mulmod (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire mexp_pkg::opnd_t a_i,
  input  wire mexp_pkg::opnd_t b_i,
  input  wire mexp_pkg::opnd_t m_i,
  output logic                 busy_o,
  output mexp_pkg::opnd_t      prod_o
);

  mexp_pkg::cnt_t  cnt_q, cnt_d;
  mexp_pkg::opnd_t acc_q, acc_d;
  mexp_pkg::opnd_t a_q, a_d;
  mexp_pkg::opnd_t mpl_q, mpl_d;

  logic [mexp_pkg::OpW:0] m_x;
  logic [mexp_pkg::OpW:0] dbl;
  logic [mexp_pkg::OpW:0] dbl_red;
  logic [mexp_pkg::OpW:0] sum;
  logic [mexp_pkg::OpW:0] sum_red;

  assign busy_o = (cnt_q != '0);
  assign prod_o = acc_q;

  always_comb begin
    m_x     = {1'b0, m_i};
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= m_x) ? (dbl - m_x) : dbl;
    sum     = {1'b0, dbl_red[mexp_pkg::OpW-1:0]} + {1'b0, a_q};
    sum_red = (sum >= m_x) ? (sum - m_x) : sum;

    cnt_d = cnt_q;
    acc_d = acc_q;
    a_d   = a_q;
    mpl_d = mpl_q;
    if (start_i) begin
      cnt_d = mexp_pkg::cnt_t'(mexp_pkg::OpW);
      acc_d = '0;
      a_d   = a_i;
      mpl_d = b_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - mexp_pkg::cnt_t'(1);
      acc_d = mpl_q[mexp_pkg::OpW-1] ? sum_red[mexp_pkg::OpW-1:0]
                                     : dbl_red[mexp_pkg::OpW-1:0];
      mpl_d = {mpl_q[mexp_pkg::OpW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    mpl_q <= mpl_d;
  end

  a_acc_below_mod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (acc_q < m_i))
    else $error("accumulator not reduced");

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("multiply started while busy");

  a_busy_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o)
    else $error("multiplier did not go busy");

endmodule

`default_nettype wire

// ----- rtl/core/mexp_seq.sv -----
// microcode sequencer: step counter, program rom lookup and conditional jumps
// depends on mexp_pkg for the rom and the control and status structs
`default_nettype none

module mexp_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mexp_pkg::status_t stat_i,
  output mexp_pkg::ctrl_t        ctrl_o
);

  mexp_pkg::pc_t    pc_q, pc_d;
  mexp_pkg::uword_t w;
  logic             jump;

  always_comb begin
    w = mexp_pkg::ucode(pc_q);
    unique case (w.cond)
      mexp_pkg::CondNone:    jump = 1'b0;
      mexp_pkg::CondAlways:  jump = 1'b1;
      mexp_pkg::CondNoInput: jump = !stat_i.in_valid;
      mexp_pkg::CondModZero: jump = stat_i.mod_zero;
      mexp_pkg::CondExpZero: jump = stat_i.exp_zero;
      mexp_pkg::CondExpEven: jump = !stat_i.exp_odd;
      mexp_pkg::CondMulBusy: jump = stat_i.mul_busy;
      mexp_pkg::CondOutFull: jump = stat_i.out_full;
    endcase

    pc_d = jump ? w.target : pc_q + mexp_pkg::pc_t'(1);

    ctrl_o.in_ready  = w.in_ready;
    ctrl_o.load      = w.in_ready & stat_i.in_valid;
    ctrl_o.mul_start = w.mul_start;
    ctrl_o.mul_sel   = w.mul_sel;
    ctrl_o.wr_b      = (w.dest == mexp_pkg::DstB) & !jump;
    ctrl_o.wr_r      = (w.dest == mexp_pkg::DstR) & !jump;
    ctrl_o.exp_shift = w.exp_shift;
    ctrl_o.emit      = w.emit & !jump;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= mexp_pkg::PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/modular_exponentiation.sv -----
// modular exponentiation, right-to-left square and multiply; one beat in, one beat out
// operands are W = 63 bits wide; the exponent is scanned from bit 0 up to its highest set bit;
// a zero modulus skips the loop and emits an error beat with a zero result
// one item at a time; the next beat is taken in PcIdle, entered from PcRestart after the emit
// asynchronous active-low reset returns the sequencer to idle and empties the output register
// depends on mexp_pkg, mexp_stream_if, mexp_mulmod and mexp_seq
`default_nettype none

module modular_exponentiation (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mexp_in_if.sink    in_i,
  mexp_out_if.source out_o
);

  mexp_pkg::status_t stat;
  mexp_pkg::ctrl_t   ctrl;

  mexp_pkg::opnd_t b_q, b_d;
  mexp_pkg::opnd_t e_q, e_d;
  mexp_pkg::opnd_t r_q, r_d;
  mexp_pkg::opnd_t m_q, m_d;
  logic            err_q, err_d;

  mexp_pkg::opnd_t in_b;
  mexp_pkg::opnd_t in_e;
  mexp_pkg::opnd_t in_m;
  mexp_pkg::opnd_t inv_e;

  mexp_pkg::opnd_t mul_a;
  logic            mul_busy;
  mexp_pkg::opnd_t mul_prod;

  logic            out_valid_q, out_valid_d;
  mexp_pkg::data_t out_result_q, out_result_d;
  logic            out_error_q, out_error_d;

  assign in_b  = in_i.base[mexp_pkg::OpW-1:0];
  assign in_e  = in_i.exponent[mexp_pkg::OpW-1:0];
  assign in_m  = in_i.modulus[mexp_pkg::OpW-1:0];
  assign inv_e = (in_m >= mexp_pkg::opnd_t'(2)) ? (in_m - mexp_pkg::opnd_t'(2)) : '0;

  mexp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  always_comb begin
    unique case (ctrl.mul_sel)
      mexp_pkg::SelReduce: mul_a = mexp_pkg::opnd_t'(1);
      mexp_pkg::SelRb:     mul_a = r_q;
      mexp_pkg::SelBb:     mul_a = b_q;
      default:             mul_a = b_q;
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.mul_start),
    .a_i     (mul_a),
    .b_i     (b_q),
    .m_i     (m_q),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  always_comb begin
    stat.in_valid = in_i.valid;
    stat.mod_zero = err_q;
    stat.exp_zero = (e_q == '0);
    stat.exp_odd  = e_q[0];
    stat.mul_busy = mul_busy;
    stat.out_full = out_valid_q & !out_o.ready;
  end

  always_comb begin
    b_d   = b_q;
    e_d   = e_q;
    r_d   = r_q;
    m_d   = m_q;
    err_d = err_q;
    if (ctrl.load) begin
      b_d   = in_b;
      e_d   = (in_i.operation == mexp_pkg::OpInverse) ? inv_e : in_e;
      r_d   = mexp_pkg::opnd_t'(1);
      m_d   = in_m;
      err_d = (in_m == '0);
    end else begin
      if (ctrl.wr_b) begin
        b_d = mul_prod;
      end
      if (ctrl.wr_r) begin
        r_d = mul_prod;
      end
      if (ctrl.exp_shift) begin
        e_d = e_q >> 1;
      end
    end
  end

  always_comb begin
    out_valid_d  = ctrl.emit | (out_valid_q & !out_o.ready);
    out_result_d = out_result_q;
    out_error_d  = out_error_q;
    if (ctrl.emit) begin
      out_result_d = err_q ? '0 : mexp_pkg::data_t'(r_q);
      out_error_d  = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q          <= b_d;
    e_q          <= e_d;
    r_q          <= r_d;
    m_q          <= m_d;
    err_q        <= err_d;
    out_result_q <= out_result_d;
    out_error_q  <= out_error_d;
  end

  assign in_i.ready   = ctrl.in_ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.result = out_result_q;
  assign out_o.error  = out_error_q;

  a_emit_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> !(out_valid_q && !out_o.ready))
    else $error("result overwritten in output register");

  a_error_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_error_q) |-> (out_result_q == '0))
    else $error("error beat with nonzero result");

  a_idle_no_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.in_ready |-> !mul_busy)
    else $error("input taken while multiplier busy");

  a_emit_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |=> !ctrl.emit)
    else $error("result emitted twice");

endmodule

`default_nettype wire
